@@ hdl/uerf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranging package
// Shared register indexes, widths and bundle types for the echo ranging block.
// ----------------------------------------------------------------------------
package uerf_pkg;

  // Configuration port geometry.
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  // Register indexes.
  localparam logic [CfgIndexWidth-1:0] CfgTriggerDivider = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CfgEchoTimeout    = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CfgSlowPrescale   = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CfgFastPrescale   = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CfgSlowCompare    = 3'd4;
  localparam logic [CfgIndexWidth-1:0] CfgFastCompare    = 3'd5;

  // Distance reported when no echo came back in time.
  localparam logic [15:0] NoEcho = 16'hFFFF;

  // Current register settings.
  typedef struct packed {
    logic [15:0] trigger_divider;
    logic [15:0] echo_limit;
    logic [7:0]  slow_prescale;
    logic [7:0]  fast_prescale;
    logic [7:0]  slow_compare;
    logic [7:0]  fast_compare;
  } cfg_t;

  // One result per tick.
  typedef struct packed {
    logic        trigger_out;
    logic        timer_reload;
    logic [7:0]  timer_prescale;
    logic [7:0]  timer_compare_value;
    logic [15:0] distance;
    logic        distance_new;
  } result_t;

endpackage

@@ hdl/uerf_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo ranging configuration registers
// Plain write port into the six timing and timer setting registers.
// ----------------------------------------------------------------------------
module uerf_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [uerf_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [uerf_pkg::CfgDataWidth-1:0]   cfg_data_i,
  output uerf_pkg::cfg_t                      cfg_o
);

  uerf_pkg::cfg_t cfg_q;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_divider <= '0;
      cfg_q.echo_limit      <= 16'hFFFF;
      cfg_q.slow_prescale   <= '0;
      cfg_q.fast_prescale   <= '0;
      cfg_q.slow_compare    <= '0;
      cfg_q.fast_compare    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        uerf_pkg::CfgTriggerDivider: cfg_q.trigger_divider <= cfg_data_i;
        uerf_pkg::CfgEchoTimeout:    cfg_q.echo_limit      <= cfg_data_i;
        uerf_pkg::CfgSlowPrescale:   cfg_q.slow_prescale   <= cfg_data_i[7:0];
        uerf_pkg::CfgFastPrescale:   cfg_q.fast_prescale   <= cfg_data_i[7:0];
        uerf_pkg::CfgSlowCompare:    cfg_q.slow_compare    <= cfg_data_i[7:0];
        uerf_pkg::CfgFastCompare:    cfg_q.fast_compare    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/uerf_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo ranging state machine
// Holds the measurement state and computes the result of each accepted tick.
// ----------------------------------------------------------------------------
module uerf_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              echo_level_i,
  input  uerf_pkg::cfg_t    cfg_i,
  output uerf_pkg::result_t result_o
);

  typedef enum logic [1:0] {
    PhTrigger,
    PhWait,
    PhEcho,
    PhTimeout
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] trigger_count_q, trigger_count_d;
  logic [15:0] wait_count_q, wait_count_d;
  logic [15:0] echo_width_q, echo_width_d;
  logic        trigger_level_q, trigger_level_d;
  logic [15:0] last_distance_q, last_distance_d;
  logic [15:0] width_inc;
  uerf_pkg::result_t res;

  // Counters stop at full scale.
  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  assign width_inc = sat_inc(echo_width_q);

  // Next state and result for one tick.
  always_comb begin
    phase_d         = phase_q;
    trigger_count_d = trigger_count_q;
    wait_count_d    = wait_count_q;
    echo_width_d    = echo_width_q;
    trigger_level_d = trigger_level_q;
    last_distance_d = last_distance_q;
    res             = '0;

    case (phase_q)
      PhTrigger: begin
        if (trigger_count_q >= cfg_i.trigger_divider) begin
          trigger_level_d         = 1'b1;
          res.timer_reload        = 1'b1;
          res.timer_prescale      = cfg_i.fast_prescale;
          res.timer_compare_value = cfg_i.fast_compare;
          phase_d                 = PhWait;
        end else begin
          trigger_count_d = sat_inc(trigger_count_q);
        end
      end
      PhWait: begin
        trigger_level_d = 1'b0;
        if (!echo_level_i) begin
          if (wait_count_q >= cfg_i.echo_limit) begin
            phase_d = PhTimeout;
          end else begin
            wait_count_d = sat_inc(wait_count_q);
          end
        end else begin
          phase_d = PhEcho;
        end
      end
      PhEcho: begin
        echo_width_d = width_inc;
        if (width_inc < cfg_i.echo_limit) begin
          if (!echo_level_i) begin
            // Falling edge: the width is the distance, then restart.
            last_distance_d         = width_inc;
            res.distance_new        = 1'b1;
            wait_count_d            = '0;
            trigger_count_d         = '0;
            echo_width_d            = '0;
            phase_d                 = PhTrigger;
            res.timer_reload        = 1'b1;
            res.timer_prescale      = cfg_i.slow_prescale;
            res.timer_compare_value = cfg_i.slow_compare;
          end
        end else begin
          phase_d = PhTimeout;
        end
      end
      PhTimeout: begin
        last_distance_d         = uerf_pkg::NoEcho;
        res.distance_new        = 1'b1;
        wait_count_d            = '0;
        trigger_count_d         = '0;
        echo_width_d            = '0;
        phase_d                 = PhTrigger;
        res.timer_reload        = 1'b1;
        res.timer_prescale      = cfg_i.slow_prescale;
        res.timer_compare_value = cfg_i.slow_compare;
      end
      default: begin
        phase_d = PhTrigger;
      end
    endcase

    res.trigger_out = trigger_level_d;
    res.distance    = last_distance_d;
  end

  // State advances only on an accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PhTrigger;
      trigger_count_q <= '0;
      wait_count_q    <= '0;
      echo_width_q    <= '0;
      trigger_level_q <= 1'b0;
      last_distance_q <= uerf_pkg::NoEcho;
    end else if (step_i) begin
      phase_q         <= phase_d;
      trigger_count_q <= trigger_count_d;
      wait_count_q    <= wait_count_d;
      echo_width_q    <= echo_width_d;
      trigger_level_q <= trigger_level_d;
      last_distance_q <= last_distance_d;
    end
  end

  assign result_o = res;

endmodule

@@ hdl/uerf_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo ranging result register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module uerf_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  uerf_pkg::result_t result_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output uerf_pkg::result_t result_o
);

  logic              valid_q;
  uerf_pkg::result_t data_q;

  // The register can take a new result when empty or being drained.
  assign free_o = !valid_q || out_ready_i;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

@@ hdl/ultrasonic_echo_ranging_fsm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranging state machine
// Each input transaction is one poll tick carrying the sampled echo level;
// each produces exactly one result transaction with the trigger level, the
// timer reload request and settings, and the last measured distance (65535
// when no echo was seen). A tick is taken every cycle the result register is
// free: the state logic is a single pass of compares and increments feeding
// that register, so a new tick is accepted whenever it is empty or being read
// in the same cycle, and the result appears in the cycle after acceptance.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranging_fsm (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [uerf_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [uerf_pkg::CfgDataWidth-1:0]  cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               echo_level_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               trigger_out_o,
  output logic                               timer_reload_o,
  output logic [7:0]                         timer_prescale_o,
  output logic [7:0]                         timer_compare_value_o,
  output logic [15:0]                        distance_o,
  output logic                               distance_new_o
);

  uerf_pkg::cfg_t    cfg;
  uerf_pkg::result_t core_res;
  uerf_pkg::result_t out_res;
  logic              free;
  logic              accept;

  assign in_ready_o = free;
  assign accept     = in_valid_i && free;

  // Configuration registers.
  uerf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Measurement state machine.
  uerf_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .echo_level_i (echo_level_i),
    .cfg_i        (cfg),
    .result_o     (core_res)
  );

  // Result register.
  uerf_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .result_i    (core_res),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign trigger_out_o         = out_res.trigger_out;
  assign timer_reload_o        = out_res.timer_reload;
  assign timer_prescale_o      = out_res.timer_prescale;
  assign timer_compare_value_o = out_res.timer_compare_value;
  assign distance_o            = out_res.distance;
  assign distance_new_o        = out_res.distance_new;

endmodule
